FILE: sv/iss_pkg.sv
package iss_pkg;

    localparam int CFG_W       = 16;
    localparam int CFG_INDEX_W = 3;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PREPARE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COOLDOWN = 3'd3;

    // command opcodes
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_ENA   = 3'd1;
    localparam logic [2:0] OP_ARM   = 3'd2;
    localparam logic [2:0] OP_FIRE  = 3'd3;
    localparam logic [2:0] OP_RESET = 3'd4;

    // phase codes
    localparam logic [2:0] PH_OFF     = 3'd0;
    localparam logic [2:0] PH_PREPARE = 3'd1;
    localparam logic [2:0] PH_HOLD    = 3'd2;
    localparam logic [2:0] PH_RELEASE = 3'd3;
    localparam logic [2:0] PH_FAULT   = 3'd4;

    localparam logic [13:0] DUTY_ON    = 14'd3000;
    localparam logic [6:0]  PERCENT_ON = 7'd30;

    localparam logic [15:0] RST_PREPARE  = 16'd10;
    localparam logic [15:0] RST_HOLD     = 16'd50;
    localparam logic [15:0] RST_RELEASE  = 16'd10;
    localparam logic [15:0] RST_COOLDOWN = 16'd100;

    typedef struct packed {
        logic [15:0] prepare_ticks;
        logic [15:0] hold_ticks;
        logic [15:0] release_ticks;
        logic [15:0] cooldown_ticks;
    } cfg_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic       value;
        logic       drive_busy;
    } cmd_t;

    typedef struct packed {
        logic        enable;
        logic        arm;
        logic        fault;
        logic        lockout;
        logic        cooldown;
        logic [2:0]  phase;
        logic [15:0] phase_count;
        logic [15:0] cooldown_count;
        logic [7:0]  shot_count;
        logic        drive_on;
    } state_t;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  phase;
        logic [13:0] drive_duty;
        logic [6:0]  output_percent;
        logic        is_enabled;
        logic        is_armed;
        logic        fault_flag;
        logic        lockout_flag;
        logic        cooling;
        logic [7:0]  shots;
        logic [15:0] cooldown_left;
    } result_t;

endpackage

FILE: sv/iss_if.sv
interface iss_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic       value;
    logic       drive_busy;

    modport source (output valid, output opcode, output value, output drive_busy,
                    input ready);
    modport sink (input valid, input opcode, input value, input drive_busy,
                  output ready);
endinterface

interface iss_res_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [2:0]  phase;
    logic [13:0] drive_duty;
    logic [6:0]  output_percent;
    logic        is_enabled;
    logic        is_armed;
    logic        fault_flag;
    logic        lockout_flag;
    logic        cooling;
    logic [7:0]  shots;
    logic [15:0] cooldown_left;

    modport source (output valid, output accepted, output phase, output drive_duty,
                    output output_percent, output is_enabled, output is_armed,
                    output fault_flag, output lockout_flag, output cooling,
                    output shots, output cooldown_left, input ready);
    modport sink (input valid, input accepted, input phase, input drive_duty,
                  input output_percent, input is_enabled, input is_armed,
                  input fault_flag, input lockout_flag, input cooling,
                  input shots, input cooldown_left, output ready);
endinterface

FILE: sv/iss_step.sv
module iss_step (
    input  iss_pkg::cfg_t    cfg,
    input  iss_pkg::cmd_t    cmd,
    input  iss_pkg::state_t  cur,
    output iss_pkg::state_t  nxt,
    output iss_pkg::result_t res
);

    always_comb
    begin
        iss_pkg::state_t s;
        logic            acc;
        logic            stop;
        logic [15:0]     cnt_inc;
        s       = cur;
        acc     = 1'b0;
        stop    = 1'b0;
        cnt_inc = cur.phase_count + 16'd1;
        case (cmd.opcode)
            iss_pkg::OP_TICK:
            begin
                if (s.cooldown)
                begin
                    if (s.cooldown_count != 16'd0)
                    begin
                        s.cooldown_count = s.cooldown_count - 16'd1;
                    end
                    if (s.cooldown_count == 16'd0)
                    begin
                        s.cooldown = 1'b0;
                    end
                end
                if (cmd.drive_busy)
                begin
                    stop = 1'b1;
                    if (s.enable || s.arm || s.phase != iss_pkg::PH_OFF)
                    begin
                        s.fault       = 1'b1;
                        s.arm         = 1'b0;
                        s.lockout     = 1'b1;
                        s.phase       = iss_pkg::PH_FAULT;
                        s.phase_count = 16'd0;
                    end
                    s.drive_on = 1'b0;
                end
                else if (s.fault)
                begin
                    stop       = 1'b1;
                    s.phase    = iss_pkg::PH_FAULT;
                    s.drive_on = 1'b0;
                end
                else if (!s.enable)
                begin
                    stop          = 1'b1;
                    s.phase       = iss_pkg::PH_OFF;
                    s.phase_count = 16'd0;
                    s.drive_on    = 1'b0;
                end
                else
                begin
                    case (s.phase)
                        iss_pkg::PH_PREPARE:
                        begin
                            s.phase_count = cnt_inc;
                            if (cnt_inc >= cfg.prepare_ticks)
                            begin
                                s.phase_count = 16'd0;
                                s.phase       = iss_pkg::PH_HOLD;
                            end
                        end
                        iss_pkg::PH_HOLD:
                        begin
                            s.phase_count = cnt_inc;
                            if (cnt_inc >= cfg.hold_ticks)
                            begin
                                s.phase_count = 16'd0;
                                s.phase       = iss_pkg::PH_RELEASE;
                            end
                        end
                        iss_pkg::PH_RELEASE:
                        begin
                            s.phase_count = cnt_inc;
                            if (cnt_inc >= cfg.release_ticks)
                            begin
                                s.phase_count    = 16'd0;
                                s.phase          = iss_pkg::PH_OFF;
                                s.arm            = 1'b0;
                                s.lockout        = 1'b1;
                                s.cooldown       = 1'b1;
                                s.cooldown_count = cfg.cooldown_ticks;
                            end
                        end
                        iss_pkg::PH_OFF:
                        begin
                            s.phase = iss_pkg::PH_OFF;
                        end
                        default:
                        begin
                            // fault phase or unused code latches a fault
                            stop          = 1'b1;
                            s.fault       = 1'b1;
                            s.arm         = 1'b0;
                            s.lockout     = 1'b1;
                            s.phase       = iss_pkg::PH_FAULT;
                            s.phase_count = 16'd0;
                            s.drive_on    = 1'b0;
                        end
                    endcase
                    if (!stop)
                    begin
                        s.drive_on = s.arm && (s.phase == iss_pkg::PH_PREPARE ||
                                               s.phase == iss_pkg::PH_HOLD);
                    end
                end
            end
            iss_pkg::OP_ENA:
            begin
                s.enable = cmd.value;
                if (!cmd.value)
                begin
                    s.arm         = 1'b0;
                    s.phase       = iss_pkg::PH_OFF;
                    s.phase_count = 16'd0;
                    s.drive_on    = 1'b0;
                end
            end
            iss_pkg::OP_ARM:
            begin
                if (cmd.value && s.enable && !s.fault && !s.lockout &&
                    !s.cooldown && !cmd.drive_busy)
                begin
                    s.arm = 1'b1;
                end
                else
                begin
                    s.arm         = 1'b0;
                    s.phase       = iss_pkg::PH_OFF;
                    s.phase_count = 16'd0;
                    s.drive_on    = 1'b0;
                end
            end
            iss_pkg::OP_FIRE:
            begin
                if (s.enable && s.arm && !s.fault && !s.lockout && !s.cooldown &&
                    s.phase == iss_pkg::PH_OFF && !cmd.drive_busy)
                begin
                    s.phase       = iss_pkg::PH_PREPARE;
                    s.phase_count = 16'd0;
                    s.shot_count  = s.shot_count + 8'd1;
                    acc           = 1'b1;
                end
            end
            iss_pkg::OP_RESET:
            begin
                if (!cmd.drive_busy && !s.cooldown)
                begin
                    s.fault       = 1'b0;
                    s.lockout     = 1'b0;
                    s.arm         = 1'b0;
                    s.shot_count  = 8'd0;
                    s.phase       = iss_pkg::PH_OFF;
                    s.phase_count = 16'd0;
                    s.drive_on    = 1'b0;
                    acc           = 1'b1;
                end
            end
            default:
            begin
                s = cur;
            end
        endcase
        nxt                = s;
        res.accepted       = acc;
        res.phase          = s.phase;
        res.drive_duty     = s.drive_on ? iss_pkg::DUTY_ON : 14'd0;
        res.output_percent = s.drive_on ? iss_pkg::PERCENT_ON : 7'd0;
        res.is_enabled     = s.enable;
        res.is_armed       = s.arm;
        res.fault_flag     = s.fault;
        res.lockout_flag   = s.lockout;
        res.cooling        = s.cooldown;
        res.shots          = s.shot_count;
        res.cooldown_left  = s.cooldown_count;
    end

endmodule

FILE: sv/interlocked_shot_sequencer.sv
// path: command register, combinational state update, result register
// throughput: one command word per cycle while results drain, set by the
//   combinational state update between the command and result registers
// reset: rst_n is asynchronous, active low; it clears all sequencer state and
//   both pipeline valids and loads the timing registers with their defaults
module interlocked_shot_sequencer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [iss_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [iss_pkg::CFG_W-1:0]             cfg_data,
    iss_cmd_if.sink                               cmd,
    iss_res_if.source                             res
);

    // timing registers
    iss_pkg::cfg_t    cfg_reg;

    // command register stage
    logic             in_full_reg;
    iss_pkg::cmd_t    in_word_reg;

    // sequencer state, updated once per command as it leaves the command register
    iss_pkg::state_t  state_reg;
    iss_pkg::state_t  state_next;

    // result register stage
    logic             out_full_reg;
    iss_pkg::result_t out_word_reg;
    iss_pkg::result_t out_word_next;

    logic             advance;

    // the command register moves on when the result slot is empty or being drained
    assign advance   = in_full_reg && (!out_full_reg || res.ready);
    assign cmd.ready = !in_full_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prepare_ticks  <= iss_pkg::RST_PREPARE;
            cfg_reg.hold_ticks     <= iss_pkg::RST_HOLD;
            cfg_reg.release_ticks  <= iss_pkg::RST_RELEASE;
            cfg_reg.cooldown_ticks <= iss_pkg::RST_COOLDOWN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                iss_pkg::REG_PREPARE:  cfg_reg.prepare_ticks  <= cfg_data;
                iss_pkg::REG_HOLD:     cfg_reg.hold_ticks     <= cfg_data;
                iss_pkg::REG_RELEASE:  cfg_reg.release_ticks  <= cfg_data;
                iss_pkg::REG_COOLDOWN: cfg_reg.cooldown_ticks <= cfg_data;
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    // command capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_full_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_word_reg.opcode     <= cmd.opcode;
            in_word_reg.value      <= cmd.value;
            in_word_reg.drive_busy <= cmd.drive_busy;
        end
    end

    iss_step u_step (
        .cfg (cfg_reg),
        .cmd (in_word_reg),
        .cur (state_reg),
        .nxt (state_next),
        .res (out_word_next)
    );

    // state and result commit together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= '0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                out_full_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign res.valid          = out_full_reg;
    assign res.accepted       = out_word_reg.accepted;
    assign res.phase          = out_word_reg.phase;
    assign res.drive_duty     = out_word_reg.drive_duty;
    assign res.output_percent = out_word_reg.output_percent;
    assign res.is_enabled     = out_word_reg.is_enabled;
    assign res.is_armed       = out_word_reg.is_armed;
    assign res.fault_flag     = out_word_reg.fault_flag;
    assign res.lockout_flag   = out_word_reg.lockout_flag;
    assign res.cooling        = out_word_reg.cooling;
    assign res.shots          = out_word_reg.shots;
    assign res.cooldown_left  = out_word_reg.cooldown_left;

`ifndef NO_ASSERTIONS
    // drive only runs in prepare or hold
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.drive_on |-> (state_reg.phase == iss_pkg::PH_PREPARE ||
                                state_reg.phase == iss_pkg::PH_HOLD))
        else $error("drive on outside prepare or hold");

    // a latched fault always carries the lockout
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.fault |-> state_reg.lockout)
        else $error("fault without lockout");

    // a stalled command stays in its register
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_full_reg && !advance) |=> in_full_reg)
        else $error("stalled command word dropped");

    // duty and percent agree in every result word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_full_reg |-> ((out_word_reg.drive_duty != 14'd0) ==
                          (out_word_reg.output_percent != 7'd0)))
        else $error("duty and percent disagree");
`endif

endmodule

FILE: bench/interlocked_shot_sequencer_test.sv
`timescale 1ns / 100ps

module interlocked_shot_sequencer_test;
    import iss_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int RESET_CYCLES = 8;
    // opcodes outside the command set, the block must ignore them
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;
    localparam logic [15:0] TICKS_MAX = 16'hffff;
    localparam logic [15:0] TICKS_ZERO = 16'h0000;
    // longest tick run used to walk one shot, keeps the extreme settings short
    localparam int SPAN_CAP = 40;

    // tracks the sequencer state and the result words it should produce
    class shot_tracker;
        logic [15:0] prepare_len;
        logic [15:0] hold_len;
        logic [15:0] release_len;
        logic [15:0] cooldown_len;

        bit          enabled;
        bit          armed;
        bit          faulted;
        bit          locked;
        bit          cooling;
        logic [2:0]  phase;
        logic [15:0] phase_ticks;
        logic [15:0] cooldown_left;
        logic [7:0]  shots;
        bit          drive_on;

        result_t     expected_words[$];
        int          mismatches;

        function new();
            prepare_len = RST_PREPARE;
            hold_len = RST_HOLD;
            release_len = RST_RELEASE;
            cooldown_len = RST_COOLDOWN;
            enabled = 1'b0;
            armed = 1'b0;
            faulted = 1'b0;
            locked = 1'b0;
            cooling = 1'b0;
            cooldown_left = '0;
            shots = '0;
            mismatches = 0;
            go_off();
        endfunction

        function void go_off();
            phase = PH_OFF;
            phase_ticks = '0;
            drive_on = 1'b0;
        endfunction

        function void trip_fault();
            faulted = 1'b1;
            armed = 1'b0;
            locked = 1'b1;
            phase = PH_FAULT;
            phase_ticks = '0;
            drive_on = 1'b0;
        endfunction

        function bit phase_elapsed(logic [15:0] limit);
            phase_ticks = phase_ticks + 16'd1;
            if (phase_ticks >= limit)
            begin
                phase_ticks = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void advance_tick(logic busy);
            if (cooling)
            begin
                if (cooldown_left > 16'd0)
                    cooldown_left = cooldown_left - 16'd1;
                if (cooldown_left == 16'd0)
                    cooling = 1'b0;
            end
            if (busy)
            begin
                if (enabled || armed || phase != PH_OFF)
                    trip_fault();
                else
                    drive_on = 1'b0;
                return;
            end
            if (faulted)
            begin
                phase = PH_FAULT;
                drive_on = 1'b0;
                return;
            end
            if (!enabled)
            begin
                go_off();
                return;
            end
            case (phase)
                PH_PREPARE:
                begin
                    if (phase_elapsed(prepare_len))
                        phase = PH_HOLD;
                end
                PH_HOLD:
                begin
                    if (phase_elapsed(hold_len))
                        phase = PH_RELEASE;
                end
                PH_RELEASE:
                begin
                    if (phase_elapsed(release_len))
                    begin
                        phase = PH_OFF;
                        armed = 1'b0;
                        locked = 1'b1;
                        cooling = 1'b1;
                        cooldown_left = cooldown_len;
                    end
                end
                PH_OFF:
                begin
                end
                default:
                begin
                    trip_fault();
                    return;
                end
            endcase
            drive_on = enabled && armed && !faulted &&
                       (phase == PH_PREPARE || phase == PH_HOLD);
        endfunction

        function void note_command(cmd_t c);
            result_t w;
            bit      ok;
            ok = 1'b0;
            case (c.opcode)
                OP_TICK:
                    advance_tick(c.drive_busy);
                OP_ENA:
                begin
                    enabled = c.value;
                    if (!enabled)
                    begin
                        armed = 1'b0;
                        go_off();
                    end
                end
                OP_ARM:
                begin
                    if (c.value && enabled && !faulted && !locked && !cooling &&
                        !c.drive_busy)
                        armed = 1'b1;
                    else
                    begin
                        armed = 1'b0;
                        go_off();
                    end
                end
                OP_FIRE:
                begin
                    if (enabled && armed && !faulted && !locked && !cooling &&
                        phase == PH_OFF && !c.drive_busy)
                    begin
                        phase = PH_PREPARE;
                        phase_ticks = '0;
                        shots = shots + 8'd1;
                        ok = 1'b1;
                    end
                end
                OP_RESET:
                begin
                    if (!c.drive_busy && !cooling)
                    begin
                        faulted = 1'b0;
                        locked = 1'b0;
                        armed = 1'b0;
                        shots = '0;
                        go_off();
                        ok = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            w.accepted = ok;
            w.phase = phase;
            w.drive_duty = drive_on ? DUTY_ON : '0;
            w.output_percent = drive_on ? PERCENT_ON : '0;
            w.is_enabled = enabled;
            w.is_armed = armed;
            w.fault_flag = faulted;
            w.lockout_flag = locked;
            w.cooling = cooling;
            w.shots = shots;
            w.cooldown_left = cooldown_left;
            expected_words.push_back(w);
        endfunction

        function void compare_field(string name, logic [15:0] exp, logic [15:0] act);
            if (act !== exp)
            begin
                $error("%s: expected %0d, got %0d", name, exp, act);
                mismatches++;
            end
        endfunction

        function void check_result(result_t r);
            result_t e;
            if (expected_words.size() == 0)
            begin
                $error("result word arrived with nothing expected");
                mismatches++;
                return;
            end
            e = expected_words.pop_front();
            compare_field("accepted", 16'(e.accepted), 16'(r.accepted));
            compare_field("phase", 16'(e.phase), 16'(r.phase));
            compare_field("drive_duty", 16'(e.drive_duty), 16'(r.drive_duty));
            compare_field("output_percent", 16'(e.output_percent),
                          16'(r.output_percent));
            compare_field("is_enabled", 16'(e.is_enabled), 16'(r.is_enabled));
            compare_field("is_armed", 16'(e.is_armed), 16'(r.is_armed));
            compare_field("fault_flag", 16'(e.fault_flag), 16'(r.fault_flag));
            compare_field("lockout_flag", 16'(e.lockout_flag), 16'(r.lockout_flag));
            compare_field("cooling", 16'(e.cooling), 16'(r.cooling));
            compare_field("shots", 16'(e.shots), 16'(r.shots));
            compare_field("cooldown_left", e.cooldown_left, r.cooldown_left);
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    iss_cmd_if cmd_bus ();
    iss_res_if res_bus ();

    shot_tracker tracker = new();

    // idle odds in percent, changed between phases
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    // cycles the result side still has to refuse words
    int hold_off_left = 0;
    // command words sent, ignored opcodes not counted
    int words_sent = 0;

    interlocked_shot_sequencer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_bus),
        .res       (res_bus)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // result side ready, driven at the falling edge
    initial
    begin
        res_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                // long hold-off so the block fills up and stalls its input
                res_bus.ready <= 1'b0;
                hold_off_left--;
            end
            else
                res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result words are sampled at the rising edge
    initial
    begin
        result_t r;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
            begin
                r.accepted = res_bus.accepted;
                r.phase = res_bus.phase;
                r.drive_duty = res_bus.drive_duty;
                r.output_percent = res_bus.output_percent;
                r.is_enabled = res_bus.is_enabled;
                r.is_armed = res_bus.is_armed;
                r.fault_flag = res_bus.fault_flag;
                r.lockout_flag = res_bus.lockout_flag;
                r.cooling = res_bus.cooling;
                r.shots = res_bus.shots;
                r.cooldown_left = res_bus.cooldown_left;
                tracker.check_result(r);
            end
        end
    end

    // generous wall for a hung handshake
    initial
    begin
        #2_000_000;
        $display("[interlocked_shot_sequencer] ERROR");
        $finish;
    end

    // offer one command word, return once it is taken
    task automatic send_word(logic [2:0] op, logic val, logic busy);
        cmd_t c;
        c.opcode = op;
        c.value = val;
        c.drive_busy = busy;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_bus.valid <= 1'b1;
        cmd_bus.opcode <= op;
        cmd_bus.value <= val;
        cmd_bus.drive_busy <= busy;
        @(posedge clk);
        while (cmd_bus.ready !== 1'b1)
            @(posedge clk);
        tracker.note_command(c);
        if (op <= OP_RESET)
            words_sent++;
    endtask

    // any opcode, any value, busy now and then
    task automatic send_noise();
        send_word(3'($urandom_range(7)), 1'($urandom_range(1)), $urandom_range(3) == 0);
    endtask

    // run of ticks; a noisy run has stray busy flags and commands mixed in
    task automatic send_ticks(int n, bit noisy);
        repeat (n)
        begin
            if (noisy && $urandom_range(19) == 0)
                send_noise();
            else
                send_word(OP_TICK, 1'($urandom_range(1)),
                          noisy && $urandom_range(39) == 0);
        end
    endtask

    // block is idle once every result word is back
    task automatic settle();
        @(negedge clk);
        cmd_bus.valid <= 1'b0;
        while (tracker.expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_PREPARE:  tracker.prepare_len = data;
            REG_HOLD:     tracker.hold_len = data;
            REG_RELEASE:  tracker.release_len = data;
            REG_COOLDOWN: tracker.cooldown_len = data;
            default:
            begin
            end
        endcase
    endtask

    task automatic load_timing(logic [15:0] p, logic [15:0] h, logic [15:0] r,
                               logic [15:0] c);
        write_reg(REG_PREPARE, p);
        write_reg(REG_HOLD, h);
        write_reg(REG_RELEASE, r);
        write_reg(REG_COOLDOWN, c);
    endtask

    // one well-formed shot with random disturbances
    task automatic run_shot();
        int span;
        int wait_ticks;
        if ($urandom_range(5) == 0)
            send_word(OP_ENA, 1'b0, 1'($urandom_range(1)));
        send_word(OP_ENA, 1'b1, 1'($urandom_range(1)));
        // reset is refused while cooling, so first tick it down, capped at SPAN_CAP
        if (tracker.cooling)
        begin
            wait_ticks = int'(tracker.cooldown_left);
            if (wait_ticks > SPAN_CAP)
                wait_ticks = SPAN_CAP;
            send_ticks(wait_ticks, 1'b0);
        end
        send_word(OP_RESET, 1'($urandom_range(1)), $urandom_range(9) == 0);
        send_word(OP_ARM, $urandom_range(9) != 0, $urandom_range(11) == 0);
        send_word(OP_FIRE, 1'($urandom_range(1)), $urandom_range(11) == 0);
        span = int'(tracker.prepare_len) + int'(tracker.hold_len) +
               int'(tracker.release_len) + int'(tracker.cooldown_len) +
               int'($urandom_range(3));
        if (span > SPAN_CAP)
            span = SPAN_CAP;
        send_ticks(span, 1'b1);
    endtask

    // mostly shots, some bursts of noise
    task automatic run_random(int n);
        int stop_at;
        stop_at = words_sent + n;
        while (words_sent < stop_at)
        begin
            if ($urandom_range(99) < 80)
                run_shot();
            else
                repeat ($urandom_range(1, 6)) send_noise();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cmd_bus.valid = 1'b0;
        cmd_bus.opcode = OP_TICK;
        cmd_bus.value = 1'b0;
        cmd_bus.drive_busy = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed, reset timing
        send_word(OP_UNUSED_LO, 1'b1, 1'b1);
        send_word(OP_UNUSED_HI, 1'b0, 1'b0);
        // busy while disengaged: no fault
        send_word(OP_TICK, 1'b0, 1'b1);
        // arm refused while disabled
        send_word(OP_ARM, 1'b1, 1'b0);
        send_word(OP_ENA, 1'b1, 1'b0);
        send_word(OP_ARM, 1'b1, 1'b1);
        send_word(OP_ARM, 1'b1, 1'b0);
        send_word(OP_FIRE, 1'b0, 1'b1);
        send_word(OP_FIRE, 1'b1, 1'b0);
        // second fire while in prepare is refused
        send_word(OP_FIRE, 1'b0, 1'b0);
        // fire alone leaves the drive off, the tick turns it on
        send_word(OP_TICK, 1'b1, 1'b0);
        send_word(OP_RESET, 1'b0, 1'b1);
        // busy while engaged latches the fault
        send_word(OP_TICK, 1'b0, 1'b1);
        send_word(OP_TICK, 1'b0, 1'b0);
        send_word(OP_ARM, 1'b1, 1'b0);
        send_word(OP_RESET, 1'b1, 1'b0);
        send_word(OP_ENA, 1'b0, 1'b0);
        settle();

        // zero lengths: each phase ends on its first tick, cooldown clears next tick
        load_timing(TICKS_ZERO, TICKS_ZERO, TICKS_ZERO, TICKS_ZERO);
        send_word(OP_ENA, 1'b1, 1'b0);
        send_word(OP_ARM, 1'b1, 1'b0);
        send_word(OP_FIRE, 1'b0, 1'b0);
        send_word(OP_TICK, 1'b0, 1'b0);
        send_word(OP_TICK, 1'b0, 1'b0);
        send_word(OP_TICK, 1'b0, 1'b0);
        send_word(OP_TICK, 1'b0, 1'b0);
        // lockout blocks the next fire until reset
        send_word(OP_FIRE, 1'b0, 1'b0);
        send_word(OP_RESET, 1'b0, 1'b0);

        // no idling, with a long receiver hold-off at the start
        hold_off_left = 60;
        run_random(200);
        settle();

        load_timing(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                    16'($urandom_range(1, 6)), 16'($urandom_range(0, 8)));
        send_idle_pct = 69;
        recv_stall_pct = 0;
        run_random(300);
        settle();

        load_timing(16'($urandom_range(0, 6)), 16'($urandom_range(1, 6)),
                    16'($urandom_range(0, 6)), 16'($urandom_range(0, 8)));
        send_idle_pct = 0;
        recv_stall_pct = 69;
        run_random(300);
        settle();

        // longest phases: shots never get past prepare
        load_timing(TICKS_MAX, TICKS_MAX, TICKS_MAX, TICKS_ZERO);
        send_idle_pct = 33;
        recv_stall_pct = 33;
        run_random(150);
        settle();

        // longest cooldown last, it locks out reset for the rest of the run
        load_timing(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                    16'($urandom_range(0, 3)), TICKS_MAX);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_random(100);

        // drain and give stray words a chance to show up
        settle();
        repeat (10) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.expected_words.size() == 0)
            $display("[interlocked_shot_sequencer] OK");
        else
            $display("[interlocked_shot_sequencer] ERROR");
        $finish;
    end

endmodule
